### rtl/ets_pkg.sv
// shared constants and the sample-to-row scaling for the edge trigger sweep capture
package ets_pkg;

  localparam int LEVEL_W = 12;
  localparam int ROW_W   = 9;
  localparam int IDX_W   = 10;

  // sweep length in samples (2 .. 1024)
  localparam logic [IDX_W:0] SWEEP_POINTS = 11'd320;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd1000;
  localparam logic [LEVEL_W-1:0] FULL_SCALE    = 12'd4095;
  localparam logic [ROW_W-1:0]   ROW_OFFSET    = 9'd44;
  localparam logic [ROW_W-1:0]   ROW_MAX       = 9'd284;

  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 8'd0,
    REG_EDGE_SELECT = 8'd1
  } cfg_reg_t;

  // row = level * 240 / 4095 + 44, no divider
  // level*240 = level*256 - level*16; quotient by 4095 from a shift and one correction
  function automatic logic [ROW_W-1:0] level_to_row(input logic [LEVEL_W-1:0] level);
    logic [19:0] prod;
    logic [7:0]  q0;
    logic [12:0] rem;
    logic [7:0]  q;
    prod = {level, 8'b0} - {4'b0, level, 4'b0};
    q0   = prod[19:12];
    rem  = {1'b0, prod[11:0]} + {5'b0, q0};
    q    = q0 + ((rem >= {1'b0, FULL_SCALE}) ? 8'd1 : 8'd0);
    return {1'b0, q} + ROW_OFFSET;
  endfunction

endpackage

### rtl/edge_trigger_sweep_capture.sv
// top level: edge trigger, sweep capture and line segment generation
// Edge-triggered single-sweep capture for a scope trace. While armed, each
// sample is compared with the one before it; a rise above the jump threshold
// (edge_select 0) or a fall below minus the threshold (edge_select 1) fires
// the trigger. The trigger sample itself is not captured. The block then
// captures SWEEP_POINTS samples, taking only items with on_period set, and
// every captured sample after the first gives one segment from column
// x_start to x_start+1, from the previous row to the current row, with
// row = sample*240/4095 + 44. The last segment of the sweep carries tlast and
// the block re-arms; the next sample becomes the new reference level.
// One item is accepted every cycle while out_tready does not hold the result
// register. An accepted item passes through one input register and then one
// result register, where out_tvalid rises with its segment. The sample to
// row scaling is a shift-and-correct quotient, so the single combinational
// stage between the two registers sets the cycle time. Configuration must
// be written only while the block is idle, which the block itself does not
// enforce; a write to an unknown index is dropped.
module edge_trigger_sweep_capture
  import ets_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  // input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [11:0] sample, [15:12] zero
  input  logic                 in_tuser,   // [0] on_period

  // result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [9:0] x_start, [18:10] y_start,
                                           // [27:19] y_end, [31:28] zero
  output logic                 out_tlast,  // frame_end

  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data
);

  // configuration registers
  logic [LEVEL_W-1:0] threshold_r;
  logic               edge_sel_r;

  // input register
  logic               in_valid_r;
  logic [LEVEL_W-1:0] sample_r;
  logic               on_period_r;

  // trigger and capture state
  logic               capturing_r, capturing_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [LEVEL_W-1:0] prev_level_r, prev_level_nxt;
  logic [IDX_W-1:0]   capture_idx_r, capture_idx_nxt;
  logic [ROW_W-1:0]   prev_row_r, prev_row_nxt;

  // result register
  logic               out_valid_r;
  logic [IDX_W-1:0]   x_start_r;
  logic [ROW_W-1:0]   y_start_r;
  logic [ROW_W-1:0]   y_end_r;
  logic               frame_end_r;

  // combinational result
  logic               res_valid;
  logic [IDX_W-1:0]   res_x;
  logic               res_last;

  logic               advance;
  logic               stage_fire;
  logic               trig_fire;
  logic [LEVEL_W:0]   rise;
  logic [LEVEL_W:0]   fall;
  logic [ROW_W-1:0]   row;
  logic               last_point;

  assign cfg_ready = 1'b1;

  // result register is free or being emptied this cycle
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign stage_fire = in_valid_r && advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      edge_sel_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold_r <= cfg_data;
        REG_EDGE_SELECT: edge_sel_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r    <= in_tdata[LEVEL_W-1:0];
      on_period_r <= in_tuser;
    end
  end

  // signed jumps in 13 bits: a rise or fall is taken only if positive
  assign rise = {1'b0, sample_r} - {1'b0, prev_level_r};
  assign fall = {1'b0, prev_level_r} - {1'b0, sample_r};

  always_comb begin
    if (!edge_sel_r) begin
      trig_fire = !rise[LEVEL_W] && (rise[LEVEL_W-1:0] > threshold_r);
    end else begin
      trig_fire = !fall[LEVEL_W] && (fall[LEVEL_W-1:0] > threshold_r);
    end
  end

  assign row        = level_to_row(sample_r);
  assign last_point = ({1'b0, capture_idx_r} + 11'd1) >= SWEEP_POINTS;

  always_comb begin
    capturing_nxt   = capturing_r;
    have_prev_nxt   = have_prev_r;
    prev_level_nxt  = prev_level_r;
    capture_idx_nxt = capture_idx_r;
    prev_row_nxt    = prev_row_r;
    res_valid       = 1'b0;
    res_x           = capture_idx_r - 10'd1;
    res_last        = last_point;

    if (stage_fire) begin
      if (!capturing_r) begin
        if (!have_prev_r) begin
          // first sample after arming is only the reference level
          prev_level_nxt = sample_r;
          have_prev_nxt  = 1'b1;
        end else if (trig_fire) begin
          capturing_nxt   = 1'b1;
          capture_idx_nxt = '0;
        end else begin
          prev_level_nxt = sample_r;
        end
      end else if (on_period_r) begin
        prev_row_nxt = row;
        if (capture_idx_r == '0) begin
          // first captured point starts the trace, no segment yet
          capture_idx_nxt = 10'd1;
        end else begin
          res_valid = 1'b1;
          if (last_point) begin
            capturing_nxt   = 1'b0;
            have_prev_nxt   = 1'b0;
            capture_idx_nxt = '0;
          end else begin
            capture_idx_nxt = capture_idx_r + 10'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r   <= 1'b0;
      have_prev_r   <= 1'b0;
      prev_level_r  <= '0;
      capture_idx_r <= '0;
      prev_row_r    <= ROW_OFFSET;
    end else begin
      capturing_r   <= capturing_nxt;
      have_prev_r   <= have_prev_nxt;
      prev_level_r  <= prev_level_nxt;
      capture_idx_r <= capture_idx_nxt;
      prev_row_r    <= prev_row_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      x_start_r   <= res_x;
      y_start_r   <= prev_row_r;
      y_end_r     <= row;
      frame_end_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, y_end_r, y_start_r, x_start_r};
  assign out_tlast  = frame_end_r;

  // segment column always inside the sweep
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, x_start_r} + 11'd2) <= SWEEP_POINTS)
    else $error("segment column past sweep end");

  // rows stay on the trace area
  a_rows_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (y_start_r >= ROW_OFFSET && y_start_r <= ROW_MAX &&
                     y_end_r >= ROW_OFFSET && y_end_r <= ROW_MAX))
    else $error("segment row outside trace area");

  // an armed block holds a cleared capture index
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    !capturing_r |-> capture_idx_r == '0)
    else $error("capture index nonzero while armed");

  // last segment of a sweep re-arms the trigger
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && res_valid && res_last) |=> (!capturing_r && !have_prev_r))
    else $error("no re-arm after last segment");

endmodule
